// ===== src/rbh_pkg.sv =====
// rbh_pkg: shared types and constants for the ray / box slab hit test
// no dependencies; used by the core, rbh_slab and the testbench
package rbh_pkg;

    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_LOW  = 3'd0,
        REG_X_HIGH = 3'd1,
        REG_Y_LOW  = 3'd2,
        REG_Y_HIGH = 3'd3,
        REG_Z_LOW  = 3'd4,
        REG_Z_HIGH = 3'd5
    } t_reg_idx;

    // per-slab status that travels next to the interval
    typedef struct packed {
        logic vld;
        logic ok;
    } t_slab_stat;

endpackage

// ===== src/ray_box_slab_hit_test_core.sv =====
// ray_box_slab_hit_test_core: top level of the ray / axis-aligned box slab hit test
// depends on rbh_pkg, rbh_slab (which holds rbh_div)
//
// channel   direction  handshake                     payload
// ray in    in         start & !busy                 origin_x/y/z, dir_x/y/z
// hit out   out        o_hit_valid, one cycle        o_hit
// config    in         i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
// one ray per cycle unless busy; the result side cannot stall, so nothing backs up
// the divider pipeline dominates the latency, one quotient bit per step stage
// synchronous active-low reset clears valid bits and loads the default box
// busy is high in reset and stays high until r_run is set
module ray_box_slab_hit_test_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [COORD_WIDTH-1:0]   i_origin_x,
    input  logic signed [COORD_WIDTH-1:0]   i_origin_y,
    input  logic signed [COORD_WIDTH-1:0]   i_origin_z,
    input  logic signed [COORD_WIDTH-1:0]   i_dir_x,
    input  logic signed [COORD_WIDTH-1:0]   i_dir_y,
    input  logic signed [COORD_WIDTH-1:0]   i_dir_z,
    output logic                            o_hit_valid,
    output logic                            o_hit,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rbh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COORD_WIDTH-1:0]          i_cfg_data
);
    localparam int W   = COORD_WIDTH;
    localparam int LAT = W + 7;
    localparam logic [W-1:0] TMIN = {1'b1, {(W-1){1'b0}}};

    // run flag: low while in reset
    logic r_run;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy        = ~r_run;
    assign accept      = start & r_run;
    assign o_cfg_ready = 1'b1;

    // box registers
    logic [W-1:0] r_box [0:rbh_pkg::NUM_REGS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box[rbh_pkg::REG_X_LOW]  <= TMIN;
            r_box[rbh_pkg::REG_X_HIGH] <= ~TMIN;
            r_box[rbh_pkg::REG_Y_LOW]  <= TMIN;
            r_box[rbh_pkg::REG_Y_HIGH] <= ~TMIN;
            r_box[rbh_pkg::REG_Z_LOW]  <= TMIN;
            r_box[rbh_pkg::REG_Z_HIGH] <= ~TMIN;
        end else if (i_cfg_valid) begin
            case (rbh_pkg::t_reg_idx'(i_cfg_index))
                rbh_pkg::REG_X_LOW:  r_box[rbh_pkg::REG_X_LOW]  <= i_cfg_data;
                rbh_pkg::REG_X_HIGH: r_box[rbh_pkg::REG_X_HIGH] <= i_cfg_data;
                rbh_pkg::REG_Y_LOW:  r_box[rbh_pkg::REG_Y_LOW]  <= i_cfg_data;
                rbh_pkg::REG_Y_HIGH: r_box[rbh_pkg::REG_Y_HIGH] <= i_cfg_data;
                rbh_pkg::REG_Z_LOW:  r_box[rbh_pkg::REG_Z_LOW]  <= i_cfg_data;
                rbh_pkg::REG_Z_HIGH: r_box[rbh_pkg::REG_Z_HIGH] <= i_cfg_data;
                default: ; // out-of-range index, write dropped
            endcase
        end
    end

    // three slabs in parallel
    rbh_pkg::t_slab_stat sx, sy, sz;
    logic signed [W-1:0] nx, fx, ny, fy, nz, fz;

    rbh_slab #(.W(W), .F(FRAC_BITS)) u_slab_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_lo(signed'(r_box[rbh_pkg::REG_X_LOW])),
        .i_hi(signed'(r_box[rbh_pkg::REG_X_HIGH])),
        .i_org(i_origin_x), .i_dir(i_dir_x),
        .o_stat(sx), .o_near(nx), .o_far(fx)
    );

    rbh_slab #(.W(W), .F(FRAC_BITS)) u_slab_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_lo(signed'(r_box[rbh_pkg::REG_Y_LOW])),
        .i_hi(signed'(r_box[rbh_pkg::REG_Y_HIGH])),
        .i_org(i_origin_y), .i_dir(i_dir_y),
        .o_stat(sy), .o_near(ny), .o_far(fy)
    );

    rbh_slab #(.W(W), .F(FRAC_BITS)) u_slab_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_lo(signed'(r_box[rbh_pkg::REG_Z_LOW])),
        .i_hi(signed'(r_box[rbh_pkg::REG_Z_HIGH])),
        .i_org(i_origin_z), .i_dir(i_dir_z),
        .o_stat(sz), .o_near(nz), .o_far(fz)
    );

    // reduce stage 1: merge x and y, carry z along
    logic                r1_vld, r1_ok;
    logic signed [W-1:0] r1_n, r1_f, r1_nz, r1_fz;
    logic                r1_okz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= sx.vld;
        end
        r1_ok  <= sx.ok & sy.ok;
        r1_n   <= (nx > ny) ? nx : ny;
        r1_f   <= (fx < fy) ? fx : fy;
        r1_nz  <= nz;
        r1_fz  <= fz;
        r1_okz <= sz.ok;
    end

    // reduce stage 2: merge z
    logic                r2_vld, r2_ok;
    logic signed [W-1:0] r2_n, r2_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_ok <= r1_ok & r1_okz;
        r2_n  <= (r1_n > r1_nz) ? r1_n : r1_nz;
        r2_f  <= (r1_f < r1_fz) ? r1_f : r1_fz;
    end

    // output register: largest near at or below smallest far
    logic r_hit_vld, r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_vld <= 1'b0;
        end else begin
            r_hit_vld <= r2_vld;
        end
        r_hit <= r2_ok && (r2_n <= r2_f);
    end

    assign o_hit_valid = r_hit_vld;
    assign o_hit       = r_hit & r_hit_vld;

    // every result traces back to one accepted ray, fixed latency
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_valid |-> $past(accept, LAT))
        else $error("result without matching ray");

    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(accept, LAT) && $past(i_rst_n, LAT) && $past(r_run, 1) |-> o_hit_valid)
        else $error("ray lost in pipeline");

    a_slab_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sx.vld == sy.vld && sy.vld == sz.vld)
        else $error("slab lanes out of step");

    a_hit_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_hit_valid)
        else $error("hit without strobe");

endmodule

// ===== src/rbh_div.sv =====
// rbh_div: pipelined fixed-point divider, t = (num << F) / den, truncated and saturated
// one restoring step per stage; depends on nothing
module rbh_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [W:0]   i_num,
    input  logic signed [W-1:0] i_den,
    output logic                o_valid,
    output logic signed [W-1:0] o_t
);
    localparam int NW = W + 1;
    localparam int CW = (F + 1 > W) ? F + 1 : W;
    localparam logic [W-1:0] LIM = {1'b1, {(W-1){1'b0}}};

    logic [NW-1:0]   n_mag;
    logic [W-1:0]    d_mag;
    logic [NW+F-1:0] n_full;
    logic [CW-1:0]   hi_ext;
    logic [CW-1:0]   d_ext;

    assign n_mag  = i_num[W] ? NW'(-i_num) : NW'(i_num);
    assign d_mag  = i_den[W-1] ? W'(-i_den) : W'(i_den);
    assign n_full = (NW+F)'(n_mag) << F;
    assign hi_ext = CW'(n_full[NW+F-1:W]);
    assign d_ext  = CW'(d_mag);

    logic [W-1:0] r_rem [0:W];
    logic [W-1:0] r_low [0:W];
    logic [W-1:0] r_q   [0:W];
    logic [W-1:0] r_den [0:W];
    logic         r_sat [0:W];
    logic         r_neg [0:W];
    logic         r_vld [0:W];

    // entry: integer-part overflow check, initial partial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0] <= hi_ext[W-1:0];
        r_low[0] <= n_full[W-1:0];
        r_q[0]   <= '0;
        r_den[0] <= d_mag;
        r_sat[0] <= (hi_ext >= d_ext);
        r_neg[0] <= i_num[W] ^ i_den[W-1];
    end

    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0] trial;
        logic [W:0] diff;
        logic       ge;
        assign trial = {r_rem[k], r_low[k][W-1]};
        assign ge    = trial >= {1'b0, r_den[k]};
        assign diff  = trial - {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1] <= ge ? diff[W-1:0] : trial[W-1:0];
            r_q[k+1]   <= {r_q[k][W-2:0], ge};
            r_low[k+1] <= r_low[k] << 1;
            r_den[k+1] <= r_den[k];
            r_sat[k+1] <= r_sat[k];
            r_neg[k+1] <= r_neg[k];
        end
    end

    // sign and saturate
    logic         pos_sat;
    logic         neg_sat;
    logic [W-1:0] t_val;
    logic         r_out_vld;
    logic [W-1:0] r_out_t;

    assign pos_sat = r_sat[W] | (r_q[W] >= LIM);
    assign neg_sat = r_sat[W] | (r_q[W] > LIM);

    always_comb begin
        if (r_neg[W]) begin
            t_val = neg_sat ? LIM : W'(-r_q[W]);
        end else begin
            t_val = pos_sat ? ~LIM : r_q[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[W];
        end
        r_out_t <= t_val;
    end

    assign o_valid = r_out_vld;
    assign o_t     = signed'(r_out_t);

endmodule

// ===== src/rbh_slab.sv =====
// rbh_slab: one axis of the slab test, two dividers plus near/far ordering
// depends on rbh_pkg and rbh_div
module rbh_slab #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_lo,
    input  logic signed [W-1:0] i_hi,
    input  logic signed [W-1:0] i_org,
    input  logic signed [W-1:0] i_dir,
    output rbh_pkg::t_slab_stat o_stat,
    output logic signed [W-1:0] o_near,
    output logic signed [W-1:0] o_far
);
    localparam int DL = W + 2;
    localparam logic [W-1:0] TMIN = {1'b1, {(W-1){1'b0}}};

    logic              r_vld;
    logic signed [W:0] r_num_a;
    logic signed [W:0] r_num_b;
    logic signed [W-1:0] r_den;
    logic              r_zero;
    logic              r_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
        r_num_a  <= (W+1)'(i_lo) - (W+1)'(i_org);
        r_num_b  <= (W+1)'(i_hi) - (W+1)'(i_org);
        r_den    <= i_dir;
        r_zero   <= (i_dir == '0);
        r_inside <= (i_lo <= i_org) && (i_org <= i_hi);
    end

    logic                va;
    logic                vb;
    logic signed [W-1:0] ta;
    logic signed [W-1:0] tb;

    rbh_div #(.W(W), .F(F)) u_div_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vld),
        .i_num(r_num_a), .i_den(r_den), .o_valid(va), .o_t(ta)
    );

    rbh_div #(.W(W), .F(F)) u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_vld),
        .i_num(r_num_b), .i_den(r_den), .o_valid(vb), .o_t(tb)
    );

    // zero-direction flags follow the divider latency
    logic r_zd  [0:DL-1];
    logic r_ins [0:DL-1];

    always_ff @(posedge i_clk) begin
        r_zd[0]  <= r_zero;
        r_ins[0] <= r_inside;
        for (int i = 1; i < DL; i++) begin
            r_zd[i]  <= r_zd[i-1];
            r_ins[i] <= r_ins[i-1];
        end
    end

    rbh_pkg::t_slab_stat r_stat;
    logic [W-1:0]        r_near;
    logic [W-1:0]        r_far;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat.vld <= 1'b0;
        end else begin
            r_stat.vld <= va & vb;
        end
        if (r_zd[DL-1]) begin
            r_stat.ok <= r_ins[DL-1];
            r_near    <= TMIN;
            r_far     <= ~TMIN;
        end else begin
            r_stat.ok <= 1'b1;
            r_near    <= (ta <= tb) ? ta : tb;
            r_far     <= (ta <= tb) ? tb : ta;
        end
    end

    assign o_stat = r_stat;
    assign o_near = signed'(r_near);
    assign o_far  = signed'(r_far);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for ray_box_slab_hit_test_core
// depends on rbh_pkg and the core; predicts each hit flag with a slab model of its own
module tb;

    localparam int W       = 32;
    localparam int FB      = 16;
    localparam int LAT     = W + 7;
    localparam int WD_LIMIT = 2000;

    localparam longint T_MAX = 64'sd2147483647;
    localparam longint T_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [W-1:0] org [3];
        logic signed [W-1:0] dir [3];
    } t_ray;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [W-1:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [W-1:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic o_hit_valid, o_hit;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [rbh_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [W-1:0] i_cfg_data = '0;

    ray_box_slab_hit_test_core #(.COORD_WIDTH(W), .FRAC_BITS(FB)) i_dut (.*);

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // testbench copy of the box: index 2a is low, 2a+1 is high
    logic signed [W-1:0] box_bound [rbh_pkg::NUM_REGS];
    bit   expected_hits [$];
    int   err_cnt = 0;
    int   idle_cycles = 0;
    bit   allow_gaps = 1'b1;

    task automatic report_mismatch(input string what);
        err_cnt++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // exact fixed-point quotient, truncated toward zero, saturated to W bits
    function automatic longint slab_t(input longint num, input longint den);
        bit      neg;
        longint  n, d, q, r, lim;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        lim = 64'sd1 <<< (W - 1);
        q = n / d;
        r = n % d;
        if (q > lim) begin
            q = lim + 1;
        end else begin
            for (int i = 0; i < FB; i++) begin
                r = r <<< 1;
                q = q <<< 1;
                if (r >= d) begin
                    r = r - d;
                    q = q | 1;
                end
                if (q > lim) begin
                    q = lim + 1;
                    break;
                end
            end
        end
        if (neg) return q > lim ? T_MIN : -q;
        return q >= lim ? T_MAX : q;
    endfunction

    function automatic bit ray_hits_box(input t_ray ray);
        longint lo, hi, o, d, ta, tb, nr, fr, best_near, best_far;
        best_near = T_MIN;
        best_far = T_MAX;
        for (int a = 0; a < 3; a++) begin
            lo = box_bound[2*a];
            hi = box_bound[2*a+1];
            o  = ray.org[a];
            d  = ray.dir[a];
            if (d == 0) begin
                // parallel to the slab: inside means unbounded, outside is a miss
                if (!(lo <= o && o <= hi)) return 1'b0;
                nr = T_MIN;
                fr = T_MAX;
            end else begin
                ta = slab_t(lo - o, d);
                tb = slab_t(hi - o, d);
                nr = ta <= tb ? ta : tb;
                fr = ta <= tb ? tb : ta;
            end
            if (nr > best_near) best_near = nr;
            if (fr < best_far) best_far = fr;
        end
        return best_near <= best_far;
    endfunction

    // result checker and watchdog, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_hit_valid) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("hit transaction with nothing expected");
            end else begin
                bit want;
                want = expected_hits.pop_front();
                if (o_hit !== want)
                    report_mismatch($sformatf("hit got %b want %b", o_hit, want));
            end
        end
        if ((start && !busy) || o_hit_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WD_LIMIT);
            $display("** ray_box_slab_hit_test_core: FAILED **");
            $finish;
        end
    end

    // one ray transaction; start stays high across back-to-back rays
    task automatic send_ray(input t_ray ray);
        start <= 1'b1;
        i_origin_x <= ray.org[0];
        i_origin_y <= ray.org[1];
        i_origin_z <= ray.org[2];
        i_dir_x <= ray.dir[0];
        i_dir_y <= ray.dir[1];
        i_dir_z <= ray.dir[2];
        do @(posedge i_clk); while (busy);
        expected_hits.insert(expected_hits.size(), ray_hits_box(ray));
        @(negedge i_clk);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding hit
    task automatic drain();
        start <= 1'b0;
        while (expected_hits.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // register write, only called while nothing is in flight
    task automatic write_bound(input rbh_pkg::t_reg_idx idx,
                               input logic signed [W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        box_bound[idx] = val;
        @(negedge i_clk);
    endtask

    task automatic write_box(input logic signed [W-1:0] b [rbh_pkg::NUM_REGS]);
        write_bound(rbh_pkg::REG_X_LOW, b[0]);
        write_bound(rbh_pkg::REG_X_HIGH, b[1]);
        write_bound(rbh_pkg::REG_Y_LOW, b[2]);
        write_bound(rbh_pkg::REG_Y_HIGH, b[3]);
        write_bound(rbh_pkg::REG_Z_LOW, b[4]);
        write_bound(rbh_pkg::REG_Z_HIGH, b[5]);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh8000_0000 + $urandom_range(0, 3);
            2: return 32'sh7fff_ffff - $urandom_range(0, 3);
            3: return $signed($urandom_range(0, 8)) - 4;
            default: return $signed($urandom_range(0, 32'h000c_0000)) - 32'sh0006_0000;
        endcase
    endfunction

    function automatic t_ray rand_ray();
        t_ray r;
        for (int a = 0; a < 3; a++) begin
            r.org[a] = rand_coord();
            r.dir[a] = ($urandom_range(0, 4) == 0) ? '0 : rand_coord();
        end
        return r;
    endfunction

    function automatic t_ray make_ray(input logic signed [W-1:0] ox, oy, oz, dx, dy, dz);
        t_ray r;
        r.org = '{ox, oy, oz};
        r.dir = '{dx, dy, dz};
        return r;
    endfunction

    // default box after reset, extreme fields, every zero-direction case
    task automatic test_directed();
        logic signed [W-1:0] unit_box [rbh_pkg::NUM_REGS];
        logic signed [W-1:0] rev_box [rbh_pkg::NUM_REGS];
        send_ray(make_ray(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        send_ray(make_ray(32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh7fff_ffff,
                          32'sh8000_0000, 1));
        send_ray(make_ray(32'sh7fff_ffff, 32'sh8000_0000, -1, 0, 0, 0));
        send_ray(make_ray(-1, -1, -1, -1, -1, -1));
        drain();
        unit_box = '{-32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000,
                     32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000};
        write_box(unit_box);
        // axis-parallel inside and outside slab, hit and miss, edge touching
        send_ray(make_ray(0, 0, 32'sh0005_0000, 0, 0, -32'sh0001_0000));
        send_ray(make_ray(32'sh0002_0000, 0, 32'sh0005_0000, 0, 0, -32'sh0001_0000));
        send_ray(make_ray(32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000));
        send_ray(make_ray(-32'sh0005_0000, 32'sh0003_0000, 0, 32'sh0001_0000,
                          -32'sh0001_0000, 0));
        send_ray(make_ray(-32'sh0005_0000, 32'sh0006_0000, 0, 32'sh0001_0000,
                          -32'sh0001_0000, 0));
        send_ray(make_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1, 1, 1));
        send_ray(make_ray(32'sh7fff_ffff, 0, 0, 32'sh8000_0000, 0, 0));
        send_ray(make_ray(0, 0, 0, 0, 0, 0));
        send_ray(make_ray(32'sh0004_0000, 0, 0, 0, 0, 0));
        drain();
        // reversed bounds: ordered for nonzero direction, a miss for zero direction
        rev_box = '{32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000,
                    -32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000};
        write_box(rev_box);
        send_ray(make_ray(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        send_ray(make_ray(0, 0, 0, 0, 32'sh0001_0000, 32'sh0001_0000));
        send_ray(make_ray(0, 0, 0, 32'sh0000_0100, -32'sh0100_0000, 3));
        drain();
    endtask

    task automatic test_random_boxes(input int n_sets, input int per_set);
        logic signed [W-1:0] b [rbh_pkg::NUM_REGS];
        logic signed [W-1:0] c, h;
        for (int s = 0; s < n_sets; s++) begin
            for (int a = 0; a < 3; a++) begin
                case ($urandom_range(0, 3))
                    0: begin b[2*a] = 32'sh8000_0000; b[2*a+1] = 32'sh7fff_ffff; end
                    1: begin b[2*a] = $urandom; b[2*a+1] = $urandom; end
                    default: begin
                        c = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
                        h = $urandom_range(0, 32'h0004_0000);
                        b[2*a] = c - h;
                        b[2*a+1] = c + h;
                    end
                endcase
            end
            write_box(b);
            for (int i = 0; i < per_set; i++) send_ray(rand_ray());
            drain();
        end
    endtask

    initial begin
        for (int i = 0; i < rbh_pkg::NUM_REGS; i++)
            box_bound[i] = (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);

        test_directed();
        test_random_boxes(12, 100);
        // full rate, no gaps, for the last part of the run
        allow_gaps = 1'b0;
        test_random_boxes(3, 150);

        @(negedge i_clk);
        start <= 1'b0;
        repeat (LAT + 10) @(negedge i_clk);
        if (err_cnt == 0 && expected_hits.size() == 0) begin
            $display("** ray_box_slab_hit_test_core: PASSED **");
        end else begin
            $display("** ray_box_slab_hit_test_core: FAILED **");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/rbh_pkg.sv
src/rbh_div.sv
src/rbh_slab.sv
src/ray_box_slab_hit_test_core.sv
tb/tb.sv
